// File: hw/rtl/bbp_pkg.sv
package bbp_pkg;

	localparam int MAX_DIMS   = 8;
	localparam int MAX_DEGREE = 15;
	localparam int FRAC_BITS  = 16;

	localparam int VAL_W   = FRAC_BITS + 1;
	localparam int DEG_W   = 4;
	localparam int DIM_W   = 4;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 2;
	// Wide enough for the largest binomial coefficient of degree fifteen.
	localparam int BINOM_W = 13;

	localparam int LANE_LAT  = MAX_DEGREE + 2;
	localparam int MERGE_LAT = MAX_DIMS + 1;
	localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

	localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	localparam logic [CIDX_W-1:0] CFG_NUM_DIMS = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_DEGREES  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_INDICES  = 2'd2;

	typedef logic [MAX_DIMS-1:0][VAL_W-1:0] fac_vec_t;

	typedef struct packed {
		logic [MAX_DIMS-1:0] use_dim;
		logic                bad;
	} merge_ctl_t;

	typedef logic [MAX_DEGREE:0][MAX_DEGREE:0][BINOM_W-1:0] binom_tab_t;

	// Pascal's triangle, built by additions only.
	function automatic binom_tab_t build_binom();
		binom_tab_t t;
		t = '0;
		for (int n = 0; n <= MAX_DEGREE; n++) begin
			for (int j = 0; j <= n; j++) begin
				if (j == 0 || j == n) begin
					t[n][j] = BINOM_W'(1);
				end else begin
					t[n][j] = t[n-1][j-1] + t[n-1][j];
				end
			end
		end
		return t;
	endfunction

	localparam binom_tab_t BINOM = build_binom();

endpackage

// File: hw/rtl/bbp_lane.sv
module bbp_lane (
	input  logic                            clk,
	input  logic                            en,
	input  logic [bbp_pkg::VAL_W-1:0]       coord,
	input  logic [bbp_pkg::DEG_W-1:0]       deg,
	input  logic [bbp_pkg::DEG_W-1:0]       idx,
	output logic [bbp_pkg::VAL_W-1:0]       fac
);

	localparam int VW = bbp_pkg::VAL_W;
	localparam int SW = bbp_pkg::VAL_W + bbp_pkg::BINOM_W;

	logic [VW-1:0] f_s   [bbp_pkg::MAX_DEGREE+1];
	logic [VW-1:0] x_s   [bbp_pkg::MAX_DEGREE];
	logic [VW-1:0] omx_s [bbp_pkg::MAX_DEGREE];
	logic [VW-1:0] fac_q;
	logic [VW-1:0] x_cl;
	logic [SW-1:0] scaled;

	assign x_cl = (coord > bbp_pkg::ONE) ? bbp_pkg::ONE : coord;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s[0]   <= bbp_pkg::ONE;
			x_s[0]   <= x_cl;
			omx_s[0] <= bbp_pkg::ONE - x_cl;
		end
	end

	// Step k multiplies by x while k < j and by one minus x while k < n.
	for (genvar k = 0; k < bbp_pkg::MAX_DEGREE; k++) begin : g_step
		logic [VW-1:0]   opnd;
		logic [2*VW-1:0] prod;

		assign opnd = (idx > bbp_pkg::DEG_W'(k)) ? x_s[k] : omx_s[k];
		assign prod = (2*VW)'(f_s[k]) * (2*VW)'(opnd);

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[k+1] <= (deg > bbp_pkg::DEG_W'(k)) ?
					prod[bbp_pkg::FRAC_BITS +: VW] : f_s[k];
			end
		end

		if (k < bbp_pkg::MAX_DEGREE - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[k+1]   <= x_s[k];
					omx_s[k+1] <= omx_s[k];
				end
			end
		end
	end

	assign scaled = SW'(f_s[bbp_pkg::MAX_DEGREE]) * SW'(bbp_pkg::BINOM[deg][idx]);

	always_ff @(posedge clk) begin
		if (en) begin
			fac_q <= (scaled > SW'(bbp_pkg::ONE)) ? bbp_pkg::ONE : scaled[VW-1:0];
		end
	end

	assign fac = fac_q;

endmodule

// File: hw/rtl/bbp_merge.sv
module bbp_merge (
	input  logic                          clk,
	input  logic                          en,
	input  bbp_pkg::fac_vec_t             fac,
	input  bbp_pkg::merge_ctl_t           ctl,
	output logic [bbp_pkg::VAL_W-1:0]     basis_value,
	output logic                          bad_index
);

	localparam int VW = bbp_pkg::VAL_W;
	localparam int ND = bbp_pkg::MAX_DIMS;

	bbp_pkg::fac_vec_t fv_s [ND-1];
	logic [VW-1:0]     p_s  [ND];
	logic [VW-1:0]     basis_value_q;
	logic              bad_index_q;

	// Stage d folds the factor of dimension d into the running product if dimension d is in use.
	for (genvar d = 0; d < ND; d++) begin : g_dim
		bbp_pkg::fac_vec_t fv_in;
		logic [VW-1:0]     p_in;
		logic [2*VW-1:0]   prod;

		if (d == 0) begin : g_first
			assign fv_in = fac;
			assign p_in  = bbp_pkg::ONE;
		end else begin : g_next
			assign fv_in = fv_s[d-1];
			assign p_in  = p_s[d-1];
		end

		assign prod = (2*VW)'(p_in) * (2*VW)'(fv_in[d]);

		always_ff @(posedge clk) begin
			if (en) begin
				if (!ctl.use_dim[d]) begin
					p_s[d] <= p_in;
				end else if (prod[2*VW-1:bbp_pkg::FRAC_BITS] > (VW+1)'(bbp_pkg::ONE)) begin
					p_s[d] <= bbp_pkg::ONE;
				end else begin
					p_s[d] <= prod[bbp_pkg::FRAC_BITS +: VW];
				end
			end
		end

		if (d < ND - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					fv_s[d] <= fv_in;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			basis_value_q <= ctl.bad ? '0 : p_s[ND-1];
			bad_index_q   <= ctl.bad;
		end
	end

	assign basis_value = basis_value_q;
	assign bad_index   = bad_index_q;

endmodule

// File: hw/rtl/bernstein_basis_product.sv
// Throughput: one beat per cycle; each dimension has its own lane of an input stage,
// fifteen multiply stages and a coefficient stage, followed by an eight-stage merge
// chain and an output register. The whole pipeline holds while the output beat is stalled.
// Reset clears the valid pipeline and sets one active dimension with degree
// and index zero.
module bernstein_basis_product (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bbp_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [bbp_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          coord_valid,
	output logic                          coord_stall,
	input  logic [bbp_pkg::VAL_W-1:0]     coord_0,
	input  logic [bbp_pkg::VAL_W-1:0]     coord_1,
	input  logic [bbp_pkg::VAL_W-1:0]     coord_2,
	input  logic [bbp_pkg::VAL_W-1:0]     coord_3,
	input  logic [bbp_pkg::VAL_W-1:0]     coord_4,
	input  logic [bbp_pkg::VAL_W-1:0]     coord_5,
	input  logic [bbp_pkg::VAL_W-1:0]     coord_6,
	input  logic [bbp_pkg::VAL_W-1:0]     coord_7,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [bbp_pkg::VAL_W-1:0]     basis_value,
	output logic                          bad_index
);

	localparam int ND = bbp_pkg::MAX_DIMS;
	localparam int DW = bbp_pkg::DEG_W;

	logic [bbp_pkg::DIM_W-1:0]   num_dims_q;
	logic [bbp_pkg::CFG_W-1:0]   degrees_q;
	logic [bbp_pkg::CFG_W-1:0]   indices_q;
	logic [bbp_pkg::TOTAL_LAT-1:0] vld_q;
	logic                        en;
	logic [bbp_pkg::DIM_W-1:0]   dims;
	logic [bbp_pkg::VAL_W-1:0]   coords [ND];
	bbp_pkg::fac_vec_t           facs;
	bbp_pkg::merge_ctl_t         ctl;
	logic [ND-1:0]               over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= bbp_pkg::DIM_W'(1);
			degrees_q  <= '0;
			indices_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bbp_pkg::CFG_NUM_DIMS: num_dims_q <= cfg_data[bbp_pkg::DIM_W-1:0];
				bbp_pkg::CFG_DEGREES:  degrees_q  <= cfg_data;
				bbp_pkg::CFG_INDICES:  indices_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en           = !vld_q[bbp_pkg::TOTAL_LAT-1] || !result_stall;
	assign coord_stall  = !en;
	assign result_valid = vld_q[bbp_pkg::TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[bbp_pkg::TOTAL_LAT-2:0], coord_valid};
		end
	end

	assign coords[0] = coord_0;
	assign coords[1] = coord_1;
	assign coords[2] = coord_2;
	assign coords[3] = coord_3;
	assign coords[4] = coord_4;
	assign coords[5] = coord_5;
	assign coords[6] = coord_6;
	assign coords[7] = coord_7;

	assign dims = (num_dims_q > bbp_pkg::DIM_W'(ND)) ? bbp_pkg::DIM_W'(ND) : num_dims_q;

	for (genvar d = 0; d < ND; d++) begin : g_lane
		logic [bbp_pkg::VAL_W-1:0] fac_d;

		assign ctl.use_dim[d] = bbp_pkg::DIM_W'(d) < dims;
		assign over[d] = ctl.use_dim[d] && (indices_q[DW*d +: DW] > degrees_q[DW*d +: DW]);
		assign facs[d] = fac_d;

		bbp_lane u_lane (
			.clk   (clk),
			.en    (en),
			.coord (coords[d]),
			.deg   (degrees_q[DW*d +: DW]),
			.idx   (indices_q[DW*d +: DW]),
			.fac   (fac_d)
		);
	end

	assign ctl.bad = |over;

	bbp_merge u_merge (
		.clk         (clk),
		.en          (en),
		.fac         (facs),
		.ctl         (ctl),
		.basis_value (basis_value),
		.bad_index   (bad_index)
	);

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_index |-> basis_value == '0)
		else $error("flagged result carries a nonzero value");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> basis_value <= bbp_pkg::ONE)
		else $error("result exceeds one");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coord_stall |-> result_valid && result_stall)
		else $error("input stalled while the output stage can move");

	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid && !coord_stall |=> vld_q[0])
		else $error("accepted beat lost at pipeline entry");

endmodule

// File: bench/testbench.sv
module testbench;

	localparam logic [bbp_pkg::CIDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int IDLE_PCT     = 33;
	localparam int NUM_DIRECTED = 20;

	typedef logic [bbp_pkg::MAX_DIMS-1:0][bbp_pkg::VAL_W-1:0] coord_set_t;

	typedef struct packed {
		logic [bbp_pkg::VAL_W-1:0] value;
		logic                      bad;
	} basis_t;

	typedef struct packed {
		logic [bbp_pkg::DIM_W-1:0] dims;
		logic [bbp_pkg::CFG_W-1:0] degrees;
		logic [bbp_pkg::CFG_W-1:0] indices;
	} setting_t;

	typedef struct packed {
		setting_t                  setting;
		logic [bbp_pkg::VAL_W-1:0] coord;
		logic                      typed;
		basis_t                    want;
	} vector_t;

	// Each row drives one coordinate on every dimension.
	localparam vector_t DIRECTED_TABLE [NUM_DIRECTED] = '{
		'{'{4'd1, 32'h0000_0000, 32'h0000_0000}, 17'h00000, 1'b1, '{bbp_pkg::ONE, 1'b0}},
		'{'{4'd1, 32'h0000_0000, 32'h0000_0000}, 17'h10000, 1'b1, '{bbp_pkg::ONE, 1'b0}},
		'{'{4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 17'h1FFFF, 1'b1, '{bbp_pkg::ONE, 1'b0}},
		'{'{4'd1, 32'h0000_0001, 32'h0000_0001}, 17'h10000, 1'b1, '{bbp_pkg::ONE, 1'b0}},
		'{'{4'd1, 32'h0000_0001, 32'h0000_0001}, 17'h00000, 1'b1, '{17'h0, 1'b0}},
		'{'{4'd1, 32'h0000_0001, 32'h0000_0001}, 17'h1FFFF, 1'b1, '{bbp_pkg::ONE, 1'b0}},
		'{'{4'd1, 32'h0000_0001, 32'h0000_0000}, 17'h00000, 1'b1, '{bbp_pkg::ONE, 1'b0}},
		'{'{4'd1, 32'h0000_000F, 32'h0000_0000}, 17'h10000, 1'b1, '{17'h0, 1'b0}},
		'{'{4'd1, 32'h0000_000F, 32'h0000_000F}, 17'h10000, 1'b1, '{bbp_pkg::ONE, 1'b0}},
		'{'{4'd1, 32'h0000_000F, 32'h0000_0007}, 17'h08000, 1'b0, '{17'h0, 1'b0}},
		'{'{4'd1, 32'h0000_0000, 32'h0000_0001}, 17'h08000, 1'b1, '{17'h0, 1'b1}},
		'{'{4'd8, 32'h2222_2222, 32'h1111_1111}, 17'h08000, 1'b0, '{17'h0, 1'b0}},
		'{'{4'd8, 32'h0222_2222, 32'h1111_1111}, 17'h08000, 1'b1, '{17'h0, 1'b1}},
		'{'{4'd7, 32'h0222_2222, 32'h1111_1111}, 17'h08000, 1'b0, '{17'h0, 1'b0}},
		'{'{4'd15, 32'h3333_3333, 32'h1230_1230}, 17'h0C000, 1'b0, '{17'h0, 1'b0}},
		'{'{4'd15, 32'hFFFF_FFFF, 32'h0000_0000}, 17'h00000, 1'b1, '{bbp_pkg::ONE, 1'b0}},
		'{'{4'd8, 32'hFFFF_FFFF, 32'h7777_7777}, 17'h08000, 1'b0, '{17'h0, 1'b0}},
		'{'{4'd8, 32'hFFFF_FFFF, 32'h8888_8888}, 17'h1FFFF, 1'b1, '{17'h0, 1'b0}},
		'{'{4'd2, 32'h0000_0034, 32'h0000_0012}, 17'h04000, 1'b0, '{17'h0, 1'b0}},
		'{'{4'd0, 32'h0000_0000, 32'h0000_000F}, 17'h00000, 1'b1, '{bbp_pkg::ONE, 1'b0}}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [bbp_pkg::CIDX_W-1:0] cfg_index;
	logic [bbp_pkg::CFG_W-1:0]  cfg_data;
	logic                       coord_valid;
	logic                       coord_stall;
	logic [bbp_pkg::VAL_W-1:0]  coord_0, coord_1, coord_2, coord_3;
	logic [bbp_pkg::VAL_W-1:0]  coord_4, coord_5, coord_6, coord_7;
	logic                       result_valid;
	logic                       result_stall;
	logic [bbp_pkg::VAL_W-1:0]  basis_value;
	logic                       bad_index;

	setting_t active;
	basis_t   pending_basis [$];
	bit       steady;
	int       errors;
	int       cycles;
	int       beats_sent;
	int       beats_checked;
	int       bad_seen;
	int       above_one;
	int       settings_loaded;

	bernstein_basis_product dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.coord_valid (coord_valid),
		.coord_stall (coord_stall),
		.coord_0     (coord_0),
		.coord_1     (coord_1),
		.coord_2     (coord_2),
		.coord_3     (coord_3),
		.coord_4     (coord_4),
		.coord_5     (coord_5),
		.coord_6     (coord_6),
		.coord_7     (coord_7),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.basis_value (basis_value),
		.bad_index   (bad_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] choose(int n, int j);
		logic [63:0] c;
		c = 64'd1;
		for (int k = 0; k < j; k++) begin
			c = c * 64'(n - k) / 64'(k + 1);
		end
		return c;
	endfunction

	function automatic basis_t predict_basis(setting_t s, coord_set_t x);
		basis_t      r;
		int          dims;
		int          n;
		int          j;
		logic [63:0] prod;
		logic [63:0] f;
		logic [63:0] v;
		dims = (s.dims > bbp_pkg::MAX_DIMS) ? bbp_pkg::MAX_DIMS : int'(s.dims);
		prod = 64'(bbp_pkg::ONE);
		r.bad = 1'b0;
		for (int d = 0; d < dims; d++) begin
			n = int'(s.degrees[bbp_pkg::DEG_W*d +: bbp_pkg::DEG_W]);
			j = int'(s.indices[bbp_pkg::DEG_W*d +: bbp_pkg::DEG_W]);
			if (j > n) begin
				r.bad = 1'b1;
			end else begin
				v = (x[d] > bbp_pkg::ONE) ? 64'(bbp_pkg::ONE) : 64'(x[d]);
				f = 64'(bbp_pkg::ONE);
				for (int k = 0; k < n; k++) begin
					f = (f * ((k < j) ? v : 64'(bbp_pkg::ONE) - v)) >> bbp_pkg::FRAC_BITS;
				end
				f = f * choose(n, j);
				if (f > 64'(bbp_pkg::ONE)) begin
					f = 64'(bbp_pkg::ONE);
				end
				prod = (prod * f) >> bbp_pkg::FRAC_BITS;
				if (prod > 64'(bbp_pkg::ONE)) begin
					prod = 64'(bbp_pkg::ONE);
				end
			end
		end
		r.value = r.bad ? '0 : bbp_pkg::VAL_W'(prod);
		return r;
	endfunction

	function automatic setting_t random_setting();
		setting_t                  s;
		logic [bbp_pkg::DEG_W-1:0] n;
		int                        bd;
		if ($urandom_range(0, 9) == 0) begin
			s.dims = bbp_pkg::DIM_W'($urandom_range(0, 15));
		end else begin
			s.dims = bbp_pkg::DIM_W'($urandom_range(1, bbp_pkg::MAX_DIMS));
		end
		for (int d = 0; d < bbp_pkg::MAX_DIMS; d++) begin
			if ($urandom_range(0, 3) == 0) begin
				n = bbp_pkg::DEG_W'($urandom_range(0, bbp_pkg::MAX_DEGREE));
			end else begin
				n = bbp_pkg::DEG_W'($urandom_range(0, 4));
			end
			s.degrees[bbp_pkg::DEG_W*d +: bbp_pkg::DEG_W] = n;
			s.indices[bbp_pkg::DEG_W*d +: bbp_pkg::DEG_W] =
				bbp_pkg::DEG_W'($urandom_range(0, n));
		end
		// Now and then one dimension gets an index above its degree.
		if ($urandom_range(0, 7) == 0) begin
			bd = $urandom_range(0, bbp_pkg::MAX_DIMS - 1);
			n = s.degrees[bbp_pkg::DEG_W*bd +: bbp_pkg::DEG_W];
			if (n == bbp_pkg::DEG_W'(bbp_pkg::MAX_DEGREE)) begin
				n = '0;
				s.degrees[bbp_pkg::DEG_W*bd +: bbp_pkg::DEG_W] = n;
			end
			s.indices[bbp_pkg::DEG_W*bd +: bbp_pkg::DEG_W] =
				bbp_pkg::DEG_W'($urandom_range(n + 1, bbp_pkg::MAX_DEGREE));
		end
		return s;
	endfunction

	function automatic logic [bbp_pkg::VAL_W-1:0] random_coord();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return bbp_pkg::ONE;
		end else if (pick == 2) begin
			return bbp_pkg::VAL_W'($urandom());
		end
		return bbp_pkg::VAL_W'($urandom_range(0, 65536));
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
	endtask

	task automatic send_coords(input coord_set_t x, input bit typed, input basis_t want);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			coord_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		coord_valid <= 1'b1;
		coord_0 <= x[0];
		coord_1 <= x[1];
		coord_2 <= x[2];
		coord_3 <= x[3];
		coord_4 <= x[4];
		coord_5 <= x[5];
		coord_6 <= x[6];
		coord_7 <= x[7];
		do @(posedge clk); while (coord_stall);
		pending_basis.push_back(typed ? want : predict_basis(active, x));
		beats_sent++;
		for (int d = 0; d < bbp_pkg::MAX_DIMS; d++) begin
			if (x[d] > bbp_pkg::ONE) begin
				above_one++;
			end
		end
	endtask

	task automatic drain();
		coord_valid <= 1'b0;
		do @(posedge clk); while (pending_basis.size() != 0);
	endtask

	task automatic write_reg(input logic [bbp_pkg::CIDX_W-1:0] idx,
			input logic [bbp_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			bbp_pkg::CFG_NUM_DIMS: active.dims = data[bbp_pkg::DIM_W-1:0];
			bbp_pkg::CFG_DEGREES:  active.degrees = data;
			bbp_pkg::CFG_INDICES:  active.indices = data;
			default: ;
		endcase
	endtask

	task automatic load_setting(input setting_t s);
		drain();
		write_reg(bbp_pkg::CFG_NUM_DIMS,
			{(bbp_pkg::CFG_W - bbp_pkg::DIM_W)'($urandom()), s.dims});
		write_reg(bbp_pkg::CFG_DEGREES, s.degrees);
		write_reg(bbp_pkg::CFG_INDICES, s.indices);
		write_reg(CFG_SPARE, $urandom());
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	always @(posedge clk) begin
		result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		basis_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_basis.size() == 0) begin
				report_mismatch("result beat with nothing pending", 32'(basis_value), 32'h0);
			end else begin
				want = pending_basis.pop_front();
				beats_checked++;
				if (bad_index) begin
					bad_seen++;
				end
				if (basis_value !== want.value) begin
					report_mismatch("basis_value", 32'(basis_value), 32'(want.value));
				end
				if (bad_index !== want.bad) begin
					report_mismatch("bad_index", 32'(bad_index), 32'(want.bad));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("bernstein_basis_product verification failed");
			$finish;
		end
	end

	initial begin
		coord_set_t x;
		setting_t   s;
		vector_t    row;
		int         phase;
		int         beats;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		coord_valid = 1'b0;
		result_stall = 1'b0;
		{coord_0, coord_1, coord_2, coord_3} = '0;
		{coord_4, coord_5, coord_6, coord_7} = '0;
		steady = 1'b0;
		errors = 0;
		cycles = 0;
		beats_sent = 0;
		beats_checked = 0;
		bad_seen = 0;
		above_one = 0;
		settings_loaded = 0;
		active = '{4'd1, 32'h0, 32'h0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_DIRECTED; r++) begin
			row = DIRECTED_TABLE[r];
			if (row.setting != active) begin
				load_setting(row.setting);
			end
			x = {bbp_pkg::MAX_DIMS{row.coord}};
			send_coords(x, row.typed, row.want);
		end

		phase = 0;
		while (beats_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
			s = random_setting();
			case (phase)
				0: begin
					s.dims = 4'd8;
					s.degrees = 32'hFFFF_FFFF;
				end
				1: s.dims = 4'd0;
				2: s.dims = 4'd15;
				3: begin
					s.dims = 4'd8;
					s.degrees = 32'h1111_1111;
					s.indices = $urandom() & 32'h1111_1111;
				end
				default: ;
			endcase
			load_setting(s);
			steady = (phase == 4);
			beats = steady ? 200 : $urandom_range(20, 120);
			for (int i = 0; i < beats; i++) begin
				for (int d = 0; d < bbp_pkg::MAX_DIMS; d++) begin
					x[d] = random_coord();
				end
				send_coords(x, 1'b0, '0);
			end
			phase++;
		end
		steady = 1'b0;

		drain();
		repeat (bbp_pkg::TOTAL_LAT + 8) @(posedge clk);
		$display("Checked %0d result beats from %0d coordinate beats over %0d settings.",
			beats_checked, beats_sent, settings_loaded);
		$display("Saw %0d bad-index results and %0d coordinates above one.",
			bad_seen, above_one);
		if (errors == 0) begin
			$display("bernstein_basis_product verification clean");
		end else begin
			$display("bernstein_basis_product verification failed");
		end
		$finish;
	end

endmodule
